>>> src/fq_alu_pkg.sv
// Shared constants, codes, stage record and helper functions of the Q24.8 ALU.
package fq_alu_pkg;

  localparam int W         = 32;                  // raw operand and result width
  localparam int FRAC      = 8;                   // fraction bits
  localparam int PROD_W    = 2 * W;
  localparam int REM_W     = W + 1;               // divisor is twice a magnitude
  localparam int DIV_STEPS = 4;                   // quotient bits per divider stage
  localparam int NUM_W     = ((W + FRAC + 2 + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
  localparam int DIV_STAGES = NUM_W / DIV_STEPS;
  localparam int IN_W      = ((4 + 2 * W + 7) / 8) * 8;
  localparam int OUT_W     = ((W + 3 + 7) / 8) * 8;

  localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MAX_NEG = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_LT       = 4'd4,
    OP_GT       = 4'd5,
    OP_LE       = 4'd6,
    OP_GE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_TO_INT   = 4'd14,
    OP_FROM_INT = 4'd15
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIVZ = 2'd2
  } status_t;

  // One pipeline slot: front-end results plus the running division.
  typedef struct packed {
    op_t                      op;
    logic signed [W-1:0]      a;
    logic signed [W-1:0]      b;
    logic [W-1:0]             res;
    logic                     cmp;
    status_t                  st;
    logic signed [PROD_W-1:0] prod;
    logic                     dneg;
    logic                     dzero;
    logic [NUM_W-1:0]         num;
    logic [REM_W-1:0]         den;
    logic [REM_W-1:0]         rem;
    logic [NUM_W-1:0]         q;
  } pipe_t;

  typedef struct packed {
    logic [W-1:0] res;
    logic         ovf;
  } sat_t;

  // Pack sign and magnitude into W bits, clamping on overflow.
  function automatic sat_t pack_sat(input logic neg, input logic [PROD_W-1:0] mag);
    sat_t r;
    r.ovf = 1'b0;
    if (neg) begin
      if (mag > PROD_W'(MAX_NEG)) begin
        r.ovf = 1'b1;
        r.res = MAX_NEG;
      end else begin
        r.res = ~mag[W-1:0] + W'(1);
      end
    end else begin
      if (mag > PROD_W'(MAX_POS)) begin
        r.ovf = 1'b1;
        r.res = MAX_POS;
      end else begin
        r.res = mag[W-1:0];
      end
    end
    return r;
  endfunction

  // Clamp a W+1 bit signed sum to W bits.
  function automatic sat_t sat_sum(input logic [W:0] s);
    sat_t r;
    r.ovf = (s[W] != s[W-1]);
    r.res = r.ovf ? (s[W] ? MAX_NEG : MAX_POS) : s[W-1:0];
    return r;
  endfunction

endpackage

>>> src/fq_div_stage.sv
// One registered stage of the restoring divider, DIV_STEPS quotient bits per stage.
module fq_div_stage import fq_alu_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  pipe_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output pipe_t out_data
);

  pipe_t step;

  always_comb begin
    logic [REM_W:0] t;
    step = in_data;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t = {step.rem, step.num[NUM_W-1]};
      step.num = {step.num[NUM_W-2:0], 1'b0};
      if (t >= {1'b0, step.den}) begin
        step.rem = REM_W'(t - {1'b0, step.den});
        step.q   = {step.q[NUM_W-2:0], 1'b1};
      end else begin
        step.rem = t[REM_W-1:0];
        step.q   = {step.q[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= step;
    end
  end

endmodule

>>> src/fixed_point_q24_8_alu_core.sv
// Top level of the signed Q24.8 fixed-point ALU stream core.
//
// Signed Q24.8 ALU: every input transaction (opcode, operand_a, operand_b)
// gives exactly one output transaction (result, compare_true, status), in
// order. The core is fully pipelined and takes one transaction per cycle
// when not stalled. Every opcode goes through stages 0 to 2, the restoring
// divider, which resolves 4 quotient bits in each of its 11 stages, and
// the output stage. Each stage holds its slot until the next one is free,
// so bubbles close up under back-pressure; nothing is dropped or repeated.
// Multiply and divide are exact and round half away from zero; add, sub,
// mul, div, inc, dec and from_int saturate and report overflow (status 1);
// divide by zero gives 0 with status 2. Comparisons return 0 in result and
// the outcome in compare_true. to_int truncates toward zero.
module fixed_point_q24_8_alu_core import fq_alu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // opcode[3:0], operand_a[35:4], operand_b[67:36]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // result[31:0], compare_true[32], status[34:33]
);

  // Unpack the incoming transaction.
  op_t               opcode;
  logic signed [W-1:0] operand_a;
  logic signed [W-1:0] operand_b;

  assign opcode    = op_t'(s_tdata[3:0]);
  assign operand_a = s_tdata[4 +: W];
  assign operand_b = s_tdata[4 + W +: W];

  // Stage 0: simple operations straight from the operands.
  pipe_t p0_next;

  always_comb begin
    sat_t            s;
    logic [W:0]      rnd;
    logic signed [W:0] ti;
    p0_next       = '0;
    p0_next.op    = opcode;
    p0_next.a     = operand_a;
    p0_next.b     = operand_b;
    p0_next.st    = ST_OK;
    s             = '0;
    rnd           = operand_a[W-1] ? (W+1)'((1 << FRAC) - 1) : '0;
    ti            = $signed({operand_a[W-1], operand_a}) + $signed(rnd);
    case (opcode)
      OP_ADD: s = sat_sum({operand_a[W-1], operand_a} + {operand_b[W-1], operand_b});
      OP_SUB: s = sat_sum({operand_a[W-1], operand_a} - {operand_b[W-1], operand_b});
      OP_INC: s = sat_sum({operand_a[W-1], operand_a} + (W+1)'(1));
      OP_DEC: s = sat_sum({operand_a[W-1], operand_a} - (W+1)'(1));
      OP_FROM_INT: begin
        s.ovf = (operand_a[W-1:W-1-FRAC] != {(FRAC+1){operand_a[W-1]}});
        s.res = s.ovf ? (operand_a[W-1] ? MAX_NEG : MAX_POS)
                      : {operand_a[W-1-FRAC:0], {FRAC{1'b0}}};
      end
      OP_TO_INT: s.res = W'(ti >>> FRAC);
      OP_MIN:    s.res = (operand_a <= operand_b) ? operand_a : operand_b;
      OP_MAX:    s.res = (operand_a >= operand_b) ? operand_a : operand_b;
      default:   s = '0;
    endcase
    p0_next.res = s.res;
    p0_next.st  = s.ovf ? ST_OVF : ST_OK;
    case (opcode)
      OP_LT:   p0_next.cmp = operand_a <  operand_b;
      OP_GT:   p0_next.cmp = operand_a >  operand_b;
      OP_LE:   p0_next.cmp = operand_a <= operand_b;
      OP_GE:   p0_next.cmp = operand_a >= operand_b;
      OP_EQ:   p0_next.cmp = operand_a == operand_b;
      OP_NE:   p0_next.cmp = operand_a != operand_b;
      default: p0_next.cmp = 1'b0;
    endcase
  end

  // Stage 1: full product and divider setup; stage 2: round the product.
  logic  v0, v1, v2, vo;
  logic  rdy0, rdy1, rdy2, rdyo;
  pipe_t p0, p1, p2, po;
  pipe_t p1_next, p2_next, po_next;

  always_comb begin
    logic [W-1:0] ma, mb;
    p1_next       = p0;
    ma            = p0.a[W-1] ? W'(-p0.a) : W'(p0.a);
    mb            = p0.b[W-1] ? W'(-p0.b) : W'(p0.b);
    p1_next.prod  = p0.a * p0.b;
    p1_next.dneg  = p0.a[W-1] ^ p0.b[W-1];
    p1_next.dzero = (p0.b == '0);
    // Numerator 2*(|a| << FRAC) + |b|, denominator 2*|b|: floor gives round half up.
    p1_next.num   = NUM_W'({ma, {FRAC{1'b0}}, 1'b0}) + NUM_W'(mb);
    p1_next.den   = {mb, 1'b0};
    p1_next.rem   = '0;
    p1_next.q     = '0;
  end

  always_comb begin
    logic [PROD_W-1:0] mag;
    sat_t              s;
    p2_next = p1;
    mag     = p1.prod[PROD_W-1] ? PROD_W'(-p1.prod) : PROD_W'(p1.prod);
    s       = pack_sat(p1.prod[PROD_W-1], (mag + PROD_W'(1 << (FRAC - 1))) >> FRAC);
    if (p1.op == OP_MUL) begin
      p2_next.res = s.res;
      p2_next.st  = s.ovf ? ST_OVF : ST_OK;
    end
  end

  // Advance each front stage when its slot is empty or drains this cycle.
  logic [DIV_STAGES:0] dv;
  logic [DIV_STAGES:0] drdy;
  pipe_t               dd [DIV_STAGES+1];

  assign rdyo     = !vo || m_tready;
  assign rdy2     = !v2 || drdy[0];
  assign rdy1     = !v1 || rdy2;
  assign rdy0     = !v0 || rdy1;
  assign s_tready = rdy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (rdy0) v0 <= s_tvalid;
      if (rdy1) v1 <= v0;
      if (rdy2) v2 <= v1;
      if (rdyo) vo <= dv[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && s_tvalid)         p0 <= p0_next;
    if (rdy1 && v0)               p1 <= p1_next;
    if (rdy2 && v1)               p2 <= p2_next;
    if (rdyo && dv[DIV_STAGES])   po <= po_next;
  end

  // Divider chain.
  assign dv[0]            = v2;
  assign dd[0]            = p2;
  assign drdy[DIV_STAGES] = rdyo;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    fq_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dv[k]),
      .in_ready  (drdy[k]),
      .in_data   (dd[k]),
      .out_valid (dv[k+1]),
      .out_ready (drdy[k+1]),
      .out_data  (dd[k+1])
    );
  end

  // Output stage: sign and clamp the quotient, or flag divide by zero.
  always_comb begin
    sat_t s;
    po_next = dd[DIV_STAGES];
    s       = pack_sat(dd[DIV_STAGES].dneg, PROD_W'(dd[DIV_STAGES].q));
    if (dd[DIV_STAGES].op == OP_DIV) begin
      if (dd[DIV_STAGES].dzero) begin
        po_next.res = '0;
        po_next.st  = ST_DIVZ;
      end else begin
        po_next.res = s.res;
        po_next.st  = s.ovf ? ST_OVF : ST_OK;
      end
    end
  end

  assign m_tvalid = vo;
  assign m_tdata  = OUT_W'({po.st, po.cmp, po.res});

endmodule

>>> sim/tb_fixed_point_q24_8_alu_core.sv
// Self-checking testbench for the Q24.8 fixed-point ALU stream core.
module tb_fixed_point_q24_8_alu_core;
  import fq_alu_pkg::*;

  // Field order follows m_tdata: status on top, compare_true, result in the low bits.
  typedef struct packed {
    status_t      st;
    logic         cmp;
    logic [W-1:0] res;
  } alu_out_t;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;

  alu_out_t pending_results[$];
  int       mismatches = 0;
  int       results_seen = 0;
  int       items_sent;
  int       cycle_count = 0;
  bit       quiet_phase;    // no idling on either side
  int       stall_left;

  localparam int LATENCY   = 15;
  localparam int MAX_CYCLES = 400000;

  fixed_point_q24_8_alu_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Clamp an exact sign/magnitude value into 32 signed bits.
  function automatic alu_out_t clamp_mag(input bit neg, input logic [79:0] mag);
    alu_out_t r;
    r = '0;
    if (neg && mag > 80'h8000_0000) begin
      r.res = MAX_NEG;
      r.st  = ST_OVF;
    end else if (!neg && mag > 80'h7FFF_FFFF) begin
      r.res = MAX_POS;
      r.st  = ST_OVF;
    end else begin
      r.res = neg ? W'(-mag) : mag[W-1:0];
    end
    return r;
  endfunction

  function automatic logic [79:0] magnitude(input logic signed [79:0] v);
    return v < 0 ? -v : v;
  endfunction

  // Exact integer evaluation of one ALU operation.
  function automatic alu_out_t alu_compute(input op_t op, input logic signed [W-1:0] a,
                                           input logic signed [W-1:0] b);
    alu_out_t r;
    logic signed [79:0] wa, wb, wide;
    logic [79:0] ma, mb, q;
    r  = '0;
    wa = a;
    wb = b;
    ma = magnitude(wa);
    mb = magnitude(wb);
    case (op)
      OP_ADD:  begin wide = wa + wb; r = clamp_mag(wide < 0, magnitude(wide)); end
      OP_SUB:  begin wide = wa - wb; r = clamp_mag(wide < 0, magnitude(wide)); end
      OP_MUL: begin
        wide = wa * wb;
        q = (magnitude(wide) + (80'd1 << (FRAC - 1))) >> FRAC;
        r = clamp_mag(wide < 0, q);
      end
      OP_DIV: begin
        if (b == 0) begin
          r.st = ST_DIVZ;
        end else begin
          q = (2 * (ma << FRAC) + mb) / (2 * mb);
          r = clamp_mag((a < 0) != (b < 0), q);
        end
      end
      OP_LT:   r.cmp = a < b;
      OP_GT:   r.cmp = a > b;
      OP_LE:   r.cmp = a <= b;
      OP_GE:   r.cmp = a >= b;
      OP_EQ:   r.cmp = a == b;
      OP_NE:   r.cmp = a != b;
      OP_MIN:  r.res = (a <= b) ? a : b;
      OP_MAX:  r.res = (a >= b) ? a : b;
      OP_INC:  begin wide = wa + 1; r = clamp_mag(wide < 0, magnitude(wide)); end
      OP_DEC:  begin wide = wa - 1; r = clamp_mag(wide < 0, magnitude(wide)); end
      OP_TO_INT: r = clamp_mag(a < 0, ma >> FRAC);
      default:   r = clamp_mag(a < 0, ma << FRAC);
    endcase
    return r;
  endfunction

  // Send one transaction, with an optional random idle burst ahead of it.
  task automatic send_op(input op_t op, input logic signed [W-1:0] a,
                         input logic signed [W-1:0] b);
    int gap;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_W'({b, a, op});
    pending_results.push_back(alu_compute(op, a, b));
    items_sent++;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic go_idle();
    s_tvalid <= 1'b0;
  endtask

  // Mix of edge values and random words, biased toward interesting operands.
  function automatic logic [W-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return MAX_POS;
      1: return MAX_NEG;
      2: return '0;
      3: return W'($urandom_range(0, 1023)) - W'(512);
      4: return W'($signed($urandom_range(0, 65535)) - 32768) <<< FRAC;
      5: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // Output side: random back-pressure, compare each transaction with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        alu_out_t got, want;
        got = alu_out_t'(m_tdata[W+2:0]);
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("unexpected result transaction: result=%h", got.res);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (got.res !== want.res) begin
            $error("result: expected %h, got %h", want.res, got.res);
            mismatches++;
          end
          if (got.cmp !== want.cmp) begin
            $error("compare_true: expected %b, got %b", want.cmp, got.cmp);
            mismatches++;
          end
          if (got.st !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, got.st);
            mismatches++;
          end
        end
      end
      // Random stall bursts; hold ready high through the quiet phase.
      if (quiet_phase) begin
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left = stall_left - 1;
        m_tready <= (stall_left == 0);
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 9);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Abort on a hung pipe.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic drain();
    go_idle();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Edge values for every opcode.
  task automatic test_directed_edges();
    op_t op;
    for (int k = 0; k < 16; k++) begin
      op = op_t'(k);
      send_op(op, MAX_POS, MAX_NEG);
    end
    send_op(OP_ADD, MAX_POS, 32'sd1);           // positive overflow
    send_op(OP_SUB, MAX_NEG, 32'sd1);           // negative overflow
    send_op(OP_MUL, 32'sh180, 32'sh1);          // tie away from zero
    send_op(OP_MUL, -32'sh180, 32'sh1);
    send_op(OP_DIV, 32'sh100, 32'sd0);          // divide by zero
    send_op(OP_DIV, 32'sh100, 32'sh300);
    send_op(OP_INC, MAX_POS, 0);
    send_op(OP_DEC, MAX_NEG, 0);
    send_op(OP_TO_INT, -32'sh1FF, 0);           // truncates toward zero
  endtask

  // Let the pipe empty completely before continuing.
  task automatic test_pause_until_empty();
    send_op(OP_EQ, 32'sd5, 32'sd5);
    drain();
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic test_random_ops(input int count);
    for (int i = 0; i < count; i++)
      send_op(op_t'($urandom_range(0, 15)), pick_operand(), pick_operand());
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    items_sent = 0;
    quiet_phase = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_pause_until_empty();
    test_random_ops(1200);
    quiet_phase = 1'b1;
    test_random_ops(300);
    drain();
    repeat (2 * LATENCY) @(posedge clk);
    $display("covered %0d transactions over all 16 opcodes, edge operands,", items_sent);
    $display("saturation, rounding ties and divide by zero; %0d results checked", results_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> sim.f
src/fq_alu_pkg.sv
src/fq_div_stage.sv
src/fixed_point_q24_8_alu_core.sv
sim/tb_fixed_point_q24_8_alu_core.sv
